>>> design/ipv4nh_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// IPv4 next-hop lookup unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipv4nh_pkg;

  localparam int IFACE_DEPTH = 4;
  localparam int ROUTE_DEPTH = 16;
  localparam int ARP_DEPTH   = 16;

  localparam int ACTION_W  = 2;
  localparam int SLOT_W    = 4;
  localparam int IP_W      = 32;
  localparam int PORT_W    = 2;
  localparam int MAC_W     = 48;
  localparam int TTL_W     = 8;
  localparam int STATUS_W  = 3;

  localparam int IFACE_CNT_W = 3;
  localparam int ROUTE_CNT_W = 5;
  localparam int ARP_CNT_W   = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam int IIDX_W = $clog2(IFACE_DEPTH);
  localparam int RIDX_W = $clog2(ROUTE_DEPTH);
  localparam int AIDX_W = $clog2(ARP_DEPTH);

  localparam int SCAN_MAX_A = (ROUTE_DEPTH > ARP_DEPTH) ? ROUTE_DEPTH : ARP_DEPTH;
  localparam int SCAN_MAX   = (IFACE_DEPTH > SCAN_MAX_A) ? IFACE_DEPTH : SCAN_MAX_A;
  localparam int IDX_W      = $clog2(SCAN_MAX + 1);

  localparam logic [ACTION_W-1:0] ACT_LOOKUP    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WR_IFACE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WR_ROUTE  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_WR_ARP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_LOCAL   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FORWARD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TTL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOROUTE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOARP   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARP_COUNT   = 2'd2;

  typedef enum logic [1:0] {
    TBL_IFACE,
    TBL_ROUTE,
    TBL_ARP
  } tbl_sel_e;

  typedef struct packed {
    logic                take_lookup;
    logic                take_write;
    tbl_sel_e            sel;
    logic                clr_idx;
    logic                inc_idx;
    logic                load_res;
    logic [STATUS_W-1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic iface_hit;
    logic ttl_low;
    logic best_valid;
    logic arp_found;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/ipv4_next_hop_lookup_unit.sv
// IPv4 next-hop lookup unit: a write item loads one entry of the interface,
// route or ARP table and gives no result. A lookup item scans the interfaces
// in use one entry per cycle (stopping early on a local hit), then the routes
// in use and the ARP entries in use, and presents its single result in the
// following cycle; a low TTL ends it after the interface scan and a missing
// route after the route scan. Each table has a single read port, stepped by
// one shared scan index. One transaction is in flight at a time. Counts are
// to be written on the configuration channel only while idle; the block
// itself does not enforce this. Depends on ipv4nh_pkg, ipv4nh_ctrl and
// ipv4nh_datapath.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_next_hop_lookup_unit
  import ipv4nh_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ACTION_W-1:0]   action_i,
  input  wire logic [SLOT_W-1:0]     slot_i,
  input  wire logic [IP_W-1:0]       address_i,
  input  wire logic [IP_W-1:0]       mask_i,
  input  wire logic [IP_W-1:0]       gateway_i,
  input  wire logic [PORT_W-1:0]     port_i,
  input  wire logic [MAC_W-1:0]      mac_i,
  input  wire logic [TTL_W-1:0]      ttl_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [PORT_W-1:0]          out_port_o,
  output logic [SLOT_W-1:0]          route_slot_o,
  output logic [MAC_W-1:0]           next_mac_o,
  output logic [TTL_W-1:0]           new_ttl_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ipv4nh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ipv4nh_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (action_i),
    .slot_i       (slot_i),
    .address_i    (address_i),
    .mask_i       (mask_i),
    .gateway_i    (gateway_i),
    .port_i       (port_i),
    .mac_i        (mac_i),
    .ttl_i        (ttl_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status_o),
    .out_port_o   (out_port_o),
    .route_slot_o (route_slot_o),
    .next_mac_o   (next_mac_o),
    .new_ttl_o    (new_ttl_o)
  );

endmodule

`default_nettype wire

>>> design/ipv4nh_ctrl.sv
// Lookup sequencer: walks the interface, route and ARP scans and hands
// commands to the datapath. Depends on ipv4nh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4nh_ctrl
  import ipv4nh_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [ACTION_W-1:0] action_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire dp_stat_t            stat_i,
  output dp_cmd_t                  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_IFACE = 3'd1;
  localparam logic [2:0] S_ROUTE = 3'd2;
  localparam logic [2:0] S_ARP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.sel   = TBL_IFACE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_LOOKUP) begin
            cmd_o.take_lookup = 1'b1;
            state_d           = S_IFACE;
          end else begin
            cmd_o.take_write = 1'b1;
          end
        end
      end
      S_IFACE: begin
        cmd_o.sel = TBL_IFACE;
        if (stat_i.idx_end) begin
          if (stat_i.ttl_low) begin
            cmd_o.load_res   = 1'b1;
            cmd_o.res_status = ST_TTL;
            state_d          = S_DONE;
          end else begin
            cmd_o.clr_idx = 1'b1;
            state_d       = S_ROUTE;
          end
        end else if (stat_i.iface_hit) begin
          cmd_o.load_res   = 1'b1;
          cmd_o.res_status = ST_LOCAL;
          state_d          = S_DONE;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_ROUTE: begin
        cmd_o.sel = TBL_ROUTE;
        if (stat_i.idx_end) begin
          if (!stat_i.best_valid) begin
            cmd_o.load_res   = 1'b1;
            cmd_o.res_status = ST_NOROUTE;
            state_d          = S_DONE;
          end else begin
            cmd_o.clr_idx = 1'b1;
            state_d       = S_ARP;
          end
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_ARP: begin
        cmd_o.sel = TBL_ARP;
        if (stat_i.idx_end) begin
          cmd_o.load_res   = 1'b1;
          cmd_o.res_status = stat_i.arp_found ? ST_FORWARD : ST_NOARP;
          state_d          = S_DONE;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/ipv4nh_datapath.sv
// Table storage, count registers, scan index, match logic and result
// registers of the next-hop lookup. Depends on ipv4nh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4nh_datapath
  import ipv4nh_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [ACTION_W-1:0]   action_i,
  input  wire logic [SLOT_W-1:0]     slot_i,
  input  wire logic [IP_W-1:0]       address_i,
  input  wire logic [IP_W-1:0]       mask_i,
  input  wire logic [IP_W-1:0]       gateway_i,
  input  wire logic [PORT_W-1:0]     port_i,
  input  wire logic [MAC_W-1:0]      mac_i,
  input  wire logic [TTL_W-1:0]      ttl_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_stat_t                   stat_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [PORT_W-1:0]          out_port_o,
  output logic [SLOT_W-1:0]          route_slot_o,
  output logic [MAC_W-1:0]           next_mac_o,
  output logic [TTL_W-1:0]           new_ttl_o
);

  logic [IP_W-1:0]   iface_ip_q      [IFACE_DEPTH];
  logic [IP_W-1:0]   route_prefix_q  [ROUTE_DEPTH];
  logic [IP_W-1:0]   route_netmask_q [ROUTE_DEPTH];
  logic [IP_W-1:0]   route_gw_q      [ROUTE_DEPTH];
  logic [PORT_W-1:0] route_port_q    [ROUTE_DEPTH];
  logic [IP_W-1:0]   arp_ip_q        [ARP_DEPTH];
  logic [MAC_W-1:0]  arp_mac_q       [ARP_DEPTH];

  logic [IFACE_CNT_W-1:0] iface_cnt_q;
  logic [ROUTE_CNT_W-1:0] route_cnt_q;
  logic [ARP_CNT_W-1:0]   arp_cnt_q;

  logic [IDX_W-1:0]  idx_q;
  logic [IP_W-1:0]   addr_q;
  logic [TTL_W-1:0]  ttl_q;
  logic              best_valid_q;
  logic [IP_W-1:0]   best_mask_q;
  logic [RIDX_W-1:0] best_idx_q;
  logic [IP_W-1:0]   best_gw_q;
  logic [PORT_W-1:0] best_port_q;
  logic              arp_found_q;
  logic [MAC_W-1:0]  hop_mac_q;

  logic [IDX_W-1:0]  n_iface, n_route, n_arp, n_sel;
  logic [RIDX_W-1:0] ridx;
  logic [AIDX_W-1:0] aidx;
  logic [IP_W-1:0]   arp_key;
  logic              route_hit, arp_hit;

  assign n_iface = (32'(iface_cnt_q) > IFACE_DEPTH) ? IDX_W'(IFACE_DEPTH)
                                                    : IDX_W'(iface_cnt_q);
  assign n_route = (32'(route_cnt_q) > ROUTE_DEPTH) ? IDX_W'(ROUTE_DEPTH)
                                                    : IDX_W'(route_cnt_q);
  assign n_arp   = (32'(arp_cnt_q) > ARP_DEPTH) ? IDX_W'(ARP_DEPTH)
                                                : IDX_W'(arp_cnt_q);

  always_comb begin
    case (cmd_i.sel)
      TBL_IFACE: n_sel = n_iface;
      TBL_ROUTE: n_sel = n_route;
      TBL_ARP:   n_sel = n_arp;
      default:   n_sel = '0;
    endcase
  end

  assign ridx    = idx_q[RIDX_W-1:0];
  assign aidx    = idx_q[AIDX_W-1:0];
  assign arp_key = (best_gw_q == '0) ? addr_q : best_gw_q;

  assign route_hit = ((addr_q & route_netmask_q[ridx]) == route_prefix_q[ridx]) &&
                     (route_netmask_q[ridx] > best_mask_q);
  assign arp_hit   = (arp_ip_q[aidx] == arp_key);

  assign stat_o.idx_end    = (idx_q >= n_sel);
  assign stat_o.iface_hit  = (iface_ip_q[idx_q[IIDX_W-1:0]] == addr_q);
  assign stat_o.ttl_low    = (ttl_q < TTL_W'(2));
  assign stat_o.best_valid = best_valid_q;
  assign stat_o.arp_found  = arp_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iface_cnt_q <= '0;
      route_cnt_q <= '0;
      arp_cnt_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IFACE_COUNT: iface_cnt_q <= cfg_data_i[IFACE_CNT_W-1:0];
        CFG_ROUTE_COUNT: route_cnt_q <= cfg_data_i[ROUTE_CNT_W-1:0];
        CFG_ARP_COUNT:   arp_cnt_q   <= cfg_data_i[ARP_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < IFACE_DEPTH; i++) iface_ip_q[i] <= '0;
      for (int i = 0; i < ROUTE_DEPTH; i++) begin
        route_prefix_q[i]  <= '0;
        route_netmask_q[i] <= '0;
        route_gw_q[i]      <= '0;
        route_port_q[i]    <= '0;
      end
      for (int i = 0; i < ARP_DEPTH; i++) begin
        arp_ip_q[i]  <= '0;
        arp_mac_q[i] <= '0;
      end
    end else if (cmd_i.take_write) begin
      unique case (action_i)
        ACT_WR_IFACE: begin
          if (32'(slot_i) < IFACE_DEPTH) iface_ip_q[slot_i[IIDX_W-1:0]] <= address_i;
        end
        ACT_WR_ROUTE: begin
          if (32'(slot_i) < ROUTE_DEPTH) begin
            route_prefix_q[slot_i[RIDX_W-1:0]]  <= address_i;
            route_netmask_q[slot_i[RIDX_W-1:0]] <= mask_i;
            route_gw_q[slot_i[RIDX_W-1:0]]      <= gateway_i;
            route_port_q[slot_i[RIDX_W-1:0]]    <= port_i;
          end
        end
        ACT_WR_ARP: begin
          if (32'(slot_i) < ARP_DEPTH) begin
            arp_ip_q[slot_i[AIDX_W-1:0]]  <= address_i;
            arp_mac_q[slot_i[AIDX_W-1:0]] <= mac_i;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      best_valid_q <= 1'b0;
      arp_found_q  <= 1'b0;
    end else begin
      if (cmd_i.take_lookup || cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.take_lookup) begin
        best_valid_q <= 1'b0;
        arp_found_q  <= 1'b0;
      end else if (cmd_i.inc_idx) begin
        if (cmd_i.sel == TBL_ROUTE && route_hit) best_valid_q <= 1'b1;
        if (cmd_i.sel == TBL_ARP && arp_hit)     arp_found_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_lookup) begin
      addr_q      <= address_i;
      ttl_q       <= ttl_i;
      best_mask_q <= '0;
      best_idx_q  <= '0;
      best_gw_q   <= '0;
      best_port_q <= '0;
      hop_mac_q   <= '0;
    end else if (cmd_i.inc_idx) begin
      if (cmd_i.sel == TBL_ROUTE && route_hit) begin
        best_mask_q <= route_netmask_q[ridx];
        best_idx_q  <= ridx;
        best_gw_q   <= route_gw_q[ridx];
        best_port_q <= route_port_q[ridx];
      end
      if (cmd_i.sel == TBL_ARP && arp_hit) begin
        hop_mac_q <= arp_mac_q[aidx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      status_o     <= cmd_i.res_status;
      out_port_o   <= '0;
      route_slot_o <= '0;
      next_mac_o   <= '0;
      new_ttl_o    <= '0;
      unique case (cmd_i.res_status)
        ST_LOCAL: begin
          out_port_o <= idx_q[PORT_W-1:0];
        end
        ST_NOARP: begin
          out_port_o   <= best_port_q;
          route_slot_o <= SLOT_W'(best_idx_q);
        end
        ST_FORWARD: begin
          out_port_o   <= best_port_q;
          route_slot_o <= SLOT_W'(best_idx_q);
          next_mac_o   <= hop_mac_q;
          new_ttl_o    <= ttl_q - TTL_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/ipv4nh_checker.sv
// Port-level assertions for the next-hop lookup unit and the bind that
// attaches them to the top level. Depends on ipv4nh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4nh_checker
  import ipv4nh_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic [ACTION_W-1:0] action_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [MAC_W-1:0]    next_mac_o,
  input wire logic [TTL_W-1:0]    new_ttl_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(next_mac_o) && $stable(new_ttl_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result waits");

  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_LOOKUP |=> !in_ready_o)
    else $error("lookup did not occupy the unit");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result repeated");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FORWARD |-> next_mac_o == '0 && new_ttl_o == '0)
    else $error("non-forward result carries next hop data");

endmodule

bind ipv4_next_hop_lookup_unit ipv4nh_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .next_mac_o  (next_mac_o),
  .new_ttl_o   (new_ttl_o)
);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for ipv4_next_hop_lookup_unit: a stimulus table, then random
// phases of table writes and lookups, scored against an in-bench next-hop predictor or,
// for typed rows, a fixed result. Depends on ipv4nh_pkg and the lookup unit RTL.
`timescale 1ns / 1ps

module tb;
  import ipv4nh_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [IP_W-1:0]     address;
    logic [IP_W-1:0]     mask;
    logic [IP_W-1:0]     gateway;
    logic [PORT_W-1:0]   port;
    logic [MAC_W-1:0]    mac;
    logic [TTL_W-1:0]    ttl;
  } hop_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   out_port;
    logic [SLOT_W-1:0]   route_slot;
    logic [MAC_W-1:0]    next_mac;
    logic [TTL_W-1:0]    new_ttl;
  } hop_res_t;

  typedef enum logic {ROW_ITEM, ROW_COUNTS} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    hop_req_t              req;
    bit                    typed;
    hop_res_t              res;
    logic [CFG_DATA_W-1:0] n_iface;
    logic [CFG_DATA_W-1:0] n_route;
    logic [CFG_DATA_W-1:0] n_arp;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic [ACTION_W-1:0]   action = '0;
  logic [SLOT_W-1:0]     slot = '0;
  logic [IP_W-1:0]       address = '0;
  logic [IP_W-1:0]       mask = '0;
  logic [IP_W-1:0]       gateway = '0;
  logic [PORT_W-1:0]     port = '0;
  logic [MAC_W-1:0]      mac = '0;
  logic [TTL_W-1:0]      ttl = '0;
  logic                  out_ready = 1'b0;

  wire                   cfg_ready;
  wire                   in_ready;
  wire                   out_valid;
  wire [STATUS_W-1:0]    status;
  wire [PORT_W-1:0]      out_port;
  wire [SLOT_W-1:0]      route_slot;
  wire [MAC_W-1:0]       next_mac;
  wire [TTL_W-1:0]       new_ttl;

  ipv4_next_hop_lookup_unit uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .slot_i       (slot),
    .address_i    (address),
    .mask_i       (mask),
    .gateway_i    (gateway),
    .port_i       (port),
    .mac_i        (mac),
    .ttl_i        (ttl),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .out_port_o   (out_port),
    .route_slot_o (route_slot),
    .next_mac_o   (next_mac),
    .new_ttl_o    (new_ttl)
  );

  always #10 clk = ~clk;

  // Predictor state: mirror of the three tables and the count registers.
  logic [IP_W-1:0]        iface_tbl [IFACE_DEPTH];
  logic [IP_W-1:0]        route_prefix_tbl [ROUTE_DEPTH];
  logic [IP_W-1:0]        route_mask_tbl [ROUTE_DEPTH];
  logic [IP_W-1:0]        route_gw_tbl [ROUTE_DEPTH];
  logic [PORT_W-1:0]      route_port_tbl [ROUTE_DEPTH];
  logic [IP_W-1:0]        arp_ip_tbl [ARP_DEPTH];
  logic [MAC_W-1:0]       arp_mac_tbl [ARP_DEPTH];
  logic [IFACE_CNT_W-1:0] iface_in_use = '0;
  logic [ROUTE_CNT_W-1:0] routes_in_use = '0;
  logic [ARP_CNT_W-1:0]   arps_in_use = '0;

  hop_res_t hop_expect_q [$];
  int       mismatches = 0;
  int       lookups_sent = 0;
  int       writes_sent = 0;
  int       count_settings = 0;
  int       status_seen [5] = '{default: 0};
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;

  initial begin
    foreach (iface_tbl[i]) iface_tbl[i] = '0;
    foreach (route_prefix_tbl[i]) begin
      route_prefix_tbl[i] = '0;
      route_mask_tbl[i]   = '0;
      route_gw_tbl[i]     = '0;
      route_port_tbl[i]   = '0;
    end
    foreach (arp_ip_tbl[i]) begin
      arp_ip_tbl[i]  = '0;
      arp_mac_tbl[i] = '0;
    end
  end

  // Apply one transaction to the mirrored tables; return 1 with the next-hop decision
  // for a lookup.
  function automatic bit resolve_hop(input hop_req_t q, output hop_res_t r);
    int              n;
    int              best;
    logic [IP_W-1:0] best_mask;
    logic [IP_W-1:0] key;
    bit              found;
    logic [MAC_W-1:0] hop_mac;
    r = '0;
    case (q.action)
      ACT_WR_IFACE: begin
        if (q.slot < IFACE_DEPTH) iface_tbl[q.slot] = q.address;
        return 1'b0;
      end
      ACT_WR_ROUTE: begin
        if (q.slot < ROUTE_DEPTH) begin
          route_prefix_tbl[q.slot] = q.address;
          route_mask_tbl[q.slot]   = q.mask;
          route_gw_tbl[q.slot]     = q.gateway;
          route_port_tbl[q.slot]   = q.port;
        end
        return 1'b0;
      end
      ACT_WR_ARP: begin
        if (q.slot < ARP_DEPTH) begin
          arp_ip_tbl[q.slot]  = q.address;
          arp_mac_tbl[q.slot] = q.mac;
        end
        return 1'b0;
      end
      default: ;
    endcase
    n = (iface_in_use > IFACE_DEPTH) ? IFACE_DEPTH : int'(iface_in_use);
    for (int i = 0; i < n; i++) begin
      if (iface_tbl[i] == q.address) begin
        r.status   = ST_LOCAL;
        r.out_port = PORT_W'(i);
        return 1'b1;
      end
    end
    if (q.ttl < 2) begin
      r.status = ST_TTL;
      return 1'b1;
    end
    n = (routes_in_use > ROUTE_DEPTH) ? ROUTE_DEPTH : int'(routes_in_use);
    best = -1;
    best_mask = '0;
    for (int i = 0; i < n; i++) begin
      if ((q.address & route_mask_tbl[i]) == route_prefix_tbl[i] &&
          route_mask_tbl[i] > best_mask) begin
        best_mask = route_mask_tbl[i];
        best = i;
      end
    end
    if (best < 0) begin
      r.status = ST_NOROUTE;
      return 1'b1;
    end
    key = (route_gw_tbl[best] == '0) ? q.address : route_gw_tbl[best];
    n = (arps_in_use > ARP_DEPTH) ? ARP_DEPTH : int'(arps_in_use);
    found = 1'b0;
    hop_mac = '0;
    for (int i = 0; i < n; i++) begin
      if (arp_ip_tbl[i] == key) begin
        hop_mac = arp_mac_tbl[i];
        found = 1'b1;
      end
    end
    r.out_port   = route_port_tbl[best];
    r.route_slot = SLOT_W'(best);
    if (!found) begin
      r.status = ST_NOARP;
      return 1'b1;
    end
    r.status   = ST_FORWARD;
    r.next_mac = hop_mac;
    r.new_ttl  = q.ttl - 1'b1;
    return 1'b1;
  endfunction

  function automatic hop_req_t mk_lookup(logic [IP_W-1:0] dst, logic [TTL_W-1:0] t);
    hop_req_t q;
    q = '0;
    q.action  = ACT_LOOKUP;
    q.address = dst;
    q.ttl     = t;
    return q;
  endfunction

  function automatic hop_req_t mk_iface(logic [SLOT_W-1:0] s, logic [IP_W-1:0] ip);
    hop_req_t q;
    q = '0;
    q.action  = ACT_WR_IFACE;
    q.slot    = s;
    q.address = ip;
    return q;
  endfunction

  function automatic hop_req_t mk_route(logic [SLOT_W-1:0] s, logic [IP_W-1:0] pfx,
                                        logic [IP_W-1:0] m, logic [IP_W-1:0] gw,
                                        logic [PORT_W-1:0] p);
    hop_req_t q;
    q = '0;
    q.action  = ACT_WR_ROUTE;
    q.slot    = s;
    q.address = pfx;
    q.mask    = m;
    q.gateway = gw;
    q.port    = p;
    return q;
  endfunction

  function automatic hop_req_t mk_arp(logic [SLOT_W-1:0] s, logic [IP_W-1:0] ip,
                                      logic [MAC_W-1:0] hw);
    hop_req_t q;
    q = '0;
    q.action  = ACT_WR_ARP;
    q.slot    = s;
    q.address = ip;
    q.mac     = hw;
    return q;
  endfunction

  function automatic hop_res_t mk_res(logic [STATUS_W-1:0] st, logic [PORT_W-1:0] p);
    hop_res_t r;
    r = '0;
    r.status   = st;
    r.out_port = p;
    return r;
  endfunction

  function automatic stim_row_t item_row(hop_req_t q);
    stim_row_t row;
    row = '{kind: ROW_ITEM, req: q, typed: 1'b0, res: '0,
            n_iface: '0, n_route: '0, n_arp: '0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(hop_req_t q, hop_res_t r);
    stim_row_t row;
    row = item_row(q);
    row.typed = 1'b1;
    row.res   = r;
    return row;
  endfunction

  function automatic stim_row_t counts_row(logic [CFG_DATA_W-1:0] ni,
                                           logic [CFG_DATA_W-1:0] nr,
                                           logic [CFG_DATA_W-1:0] na);
    stim_row_t row;
    row = item_row('0);
    row.kind    = ROW_COUNTS;
    row.n_iface = ni;
    row.n_route = nr;
    row.n_arp   = na;
    return row;
  endfunction

  // Mostly addresses in a small 10.x.y.z pool so that tables and lookups collide.
  function automatic logic [IP_W-1:0] pick_host();
    if ($urandom_range(0, 9) < 7)
      return 32'h0A00_0000 | ($urandom_range(0, 3) << 16) | ($urandom_range(0, 3) << 8) |
             $urandom_range(0, 7);
    return $urandom();
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(int depth);
    if ($urandom_range(0, 99) < 85) return SLOT_W'($urandom_range(0, depth - 1));
    return SLOT_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count(int depth, int top);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_DATA_W'(top);
      2: return CFG_DATA_W'(depth);
      default: return CFG_DATA_W'($urandom_range(0, top));
    endcase
  endfunction

  function automatic hop_req_t gen_random_item();
    hop_req_t q;
    int       r;
    int       k;
    int       len;
    q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    r = $urandom_range(0, 99);
    if (r < 15) begin
      q.action  = ACT_WR_IFACE;
      q.slot    = pick_slot(IFACE_DEPTH);
      q.address = pick_host();
    end else if (r < 35) begin
      q.action = ACT_WR_ROUTE;
      q.slot   = pick_slot(ROUTE_DEPTH);
      len = $urandom_range(0, 32);
      q.mask = (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
      if ($urandom_range(0, 9) == 0) q.mask = $urandom();
      q.address = pick_host();
      if ($urandom_range(0, 9) != 0) q.address = q.address & q.mask;
      q.gateway = ($urandom_range(0, 9) < 4) ? '0 : pick_host();
    end else if (r < 50) begin
      q.action = ACT_WR_ARP;
      q.slot   = pick_slot(ARP_DEPTH);
      k = $urandom_range(0, ROUTE_DEPTH - 1);
      q.address = ($urandom_range(0, 1) && route_gw_tbl[k] != '0) ? route_gw_tbl[k]
                                                                  : pick_host();
      case ($urandom_range(0, 19))
        0, 1: q.mac = '1;
        2:    q.mac = '0;
        default: ;
      endcase
    end else begin
      q.action = ACT_LOOKUP;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        q.address = iface_tbl[$urandom_range(0, IFACE_DEPTH - 1)];
      end else if (r < 75) begin
        k = $urandom_range(0, ROUTE_DEPTH - 1);
        q.address = route_prefix_tbl[k] | ($urandom() & ~route_mask_tbl[k]);
      end else begin
        q.address = pick_host();
      end
      r = $urandom_range(0, 99);
      if (r < 15) q.ttl = TTL_W'($urandom_range(0, 2));
      else if (r < 20) q.ttl = '1;
    end
    return q;
  endfunction

  // Offer one transaction, optionally after an idle burst, and predict it on acceptance.
  task automatic send_item(input hop_req_t q, input bit typed, input hop_res_t typed_res);
    hop_res_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= q.action;
    slot     <= q.slot;
    address  <= q.address;
    mask     <= q.mask;
    gateway  <= q.gateway;
    port     <= q.port;
    mac      <= q.mac;
    ttl      <= q.ttl;
    do @(posedge clk); while (!in_ready);
    if (resolve_hop(q, r)) begin
      hop_expect_q.push_back(typed ? typed_res : r);
      lookups_sent++;
    end else begin
      writes_sent++;
    end
  endtask

  // Drain the unit, then program all three count registers.
  task automatic write_counts(input logic [CFG_DATA_W-1:0] ni,
                              input logic [CFG_DATA_W-1:0] nr,
                              input logic [CFG_DATA_W-1:0] na);
    logic [CFG_DATA_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0]  idx [3];
    vals = '{ni, nr, na};
    idx  = '{CFG_IFACE_COUNT, CFG_ROUTE_COUNT, CFG_ARP_COUNT};
    in_valid <= 1'b0;
    while (hop_expect_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_IFACE_COUNT: iface_in_use  = vals[i][IFACE_CNT_W-1:0];
        CFG_ROUTE_COUNT: routes_in_use = vals[i][ROUTE_CNT_W-1:0];
        CFG_ARP_COUNT:   arps_in_use   = vals[i][ARP_CNT_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    count_settings++;
  endtask

  // Result side: random stalls, one long hold-off on request, steady ready when calm.
  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : score
    hop_res_t got;
    hop_res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{status, out_port, route_slot, next_mac, new_ttl};
      if (got.status < 5) status_seen[got.status]++;
      if (hop_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: status %0d port %0d slot %0d mac %h ttl %0d",
                   got.status, got.out_port, got.route_slot, got.next_mac, got.new_ttl);
      end else begin
        want = hop_expect_q.pop_front();
        if (got.status !== want.status || got.out_port !== want.out_port ||
            got.route_slot !== want.route_slot || got.next_mac !== want.next_mac ||
            got.new_ttl !== want.new_ttl) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected st %0d port %0d slot %0d mac %h ttl %0d, got st %0d port %0d slot %0d mac %h ttl %0d",
                     $realtime, want.status, want.out_port, want.route_slot,
                     want.next_mac, want.new_ttl, got.status, got.out_port,
                     got.route_slot, got.next_mac, got.new_ttl);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    stim_row_t rows [$];
    rows.push_back(typed_row(mk_lookup(32'h0000_0000, 8'd0), mk_res(ST_TTL, 2'd0)));
    rows.push_back(typed_row(mk_lookup(32'hFFFF_FFFF, 8'hFF), mk_res(ST_NOROUTE, 2'd0)));
    rows.push_back(item_row(mk_iface(4'd0, 32'h0A00_0001)));
    rows.push_back(item_row(mk_iface(4'd3, 32'hFFFF_FFFF)));
    rows.push_back(item_row(mk_iface(4'd7, 32'hC0A8_0001)));
    rows.push_back(item_row(mk_route(4'd0, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 2'd1)));
    rows.push_back(item_row(mk_route(4'd1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A00_0002,
                                     2'd2)));
    rows.push_back(item_row(mk_route(4'd2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0, 2'd3)));
    rows.push_back(item_row(mk_route(4'd15, 32'h0, 32'h0, 32'hFFFF_FFFF, 2'd3)));
    rows.push_back(item_row(mk_route(4'd3, 32'h0, 32'hFFFF_FFFF, 32'h0, 2'd0)));
    rows.push_back(item_row(mk_arp(4'd0, 32'h0A00_0002, 48'h1111_1111_1111)));
    rows.push_back(item_row(mk_arp(4'd15, 32'h0A00_0002, 48'hFFFF_FFFF_FFFF)));
    rows.push_back(item_row(mk_arp(4'd1, 32'h0A02_0304, 48'h0)));
    rows.push_back(counts_row(5'd7, 5'd31, 5'd31));
    rows.push_back(typed_row(mk_lookup(32'h0A00_0001, 8'd0), mk_res(ST_LOCAL, 2'd0)));
    rows.push_back(typed_row(mk_lookup(32'hFFFF_FFFF, 8'd1), mk_res(ST_LOCAL, 2'd3)));
    rows.push_back(item_row(mk_lookup(32'h0A01_0203, 8'd2)));
    rows.push_back(item_row(mk_lookup(32'h0A02_0304, 8'd255)));
    rows.push_back(item_row(mk_lookup(32'h0A05_0505, 8'd64)));
    rows.push_back(typed_row(mk_lookup(32'h0B00_0000, 8'd64), mk_res(ST_NOROUTE, 2'd0)));
    rows.push_back(typed_row(mk_lookup(32'h0000_0000, 8'd10), mk_res(ST_LOCAL, 2'd1)));
    rows.push_back(item_row(mk_lookup(32'hC0A8_0001, 8'd64)));
    rows.push_back(counts_row(5'd0, 5'd0, 5'd0));
    rows.push_back(typed_row(mk_lookup(32'h0A00_0001, 8'd0), mk_res(ST_TTL, 2'd0)));
    rows.push_back(typed_row(mk_lookup(32'h0A01_0203, 8'd9), mk_res(ST_NOROUTE, 2'd0)));
    rows.push_back(counts_row(5'd1, 5'd2, 5'd1));
    rows.push_back(item_row(mk_lookup(32'h0A01_0203, 8'd100)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_COUNTS)
        write_counts(rows[i].n_iface, rows[i].n_route, rows[i].n_arp);
      else
        send_item(rows[i].req, rows[i].typed, rows[i].res);
    end

    for (int p = 0; p < 14; p++) begin
      if (p == 13) calm = 1'b1;
      write_counts(pick_count(IFACE_DEPTH, 7), pick_count(ROUTE_DEPTH, 31),
                   pick_count(ARP_DEPTH, 31));
      for (int k = 0; k < 60; k++) begin
        if (p == 2 && k == 10) hold_req = 1'b1;
        send_item(gen_random_item(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (hop_expect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d lookups and %0d table writes under %0d count settings.",
             lookups_sent, writes_sent, count_settings);
    $display("Results: local %0d, forward %0d, ttl %0d, no route %0d, no arp %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ipv4nh_pkg.sv
design/ipv4nh_ctrl.sv
design/ipv4nh_datapath.sv
design/ipv4_next_hop_lookup_unit.sv
design/ipv4nh_checker.sv
test/tb.sv
